[src/dual_core_priority_dispatcher_core_defines.svh]
// assertion macros for the dual core priority dispatcher
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef DUAL_CORE_PRIORITY_DISPATCHER_CORE_DEFINES_SVH
`define DUAL_CORE_PRIORITY_DISPATCHER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DCPD_ASSERT_NOW(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |-> (rhs)) \
        else $error("dispatcher check failed");

// next-cycle implication, checked outside reset
`define DCPD_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |=> (rhs)) \
        else $error("dispatcher check failed");

`endif

[src/dcpd_pkg.sv]
// shared types, constants and helpers for the dual core priority dispatcher
// no dependencies
`timescale 1ns / 1ps

package dcpd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    localparam int NUM_DEV = 3;
    localparam int NUM_Q   = 3;

    // ready queue indexes
    localparam int Q_HIGH = 0;
    localparam int Q_LOW  = 1;
    localparam int Q_DISK = 2;

    typedef logic [1:0] t_dev;

    localparam t_dev DEV_CORE0 = 2'd0;
    localparam t_dev DEV_CORE1 = 2'd1;
    localparam t_dev DEV_DISK  = 2'd2;
    localparam t_dev DEV_NONE  = 2'd3;

    typedef enum logic [1:0] {
        CMD_CPU_REQ   = 2'd0,
        CMD_CORE_DONE = 2'd1,
        CMD_DISK_REQ  = 2'd2,
        CMD_DISK_DONE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [7:0]  proc;
        logic [15:0] service;
    } t_entry;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
    } t_fifo_ctl;

    typedef struct packed {
        logic   empty;
        logic   full;
        t_entry head;
    } t_fifo_stat;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] clock_now;
        logic [15:0] request_time;
        logic [7:0]  process_id;
        logic        high_priority;
        logic        core_index;
    } t_in_word;

    typedef struct packed {
        logic        started_running;
        logic        queue_full;
        logic        popped_valid;
        logic [7:0]  popped_process;
        t_dev        next_device;
        logic [7:0]  next_process;
        logic [31:0] next_time;
        logic [31:0] core_busy_total;
        logic [31:0] disk_busy_total;
    } t_out_word;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[src/dcpd_in_if.sv]
// valid/ready channel carrying one dispatcher event word
// no dependencies
`timescale 1ns / 1ps

interface dcpd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] clock_now;
    logic [15:0] request_time;
    logic [7:0]  process_id;
    logic        high_priority;
    logic        core_index;

    modport source (
        output valid, cmd, clock_now, request_time, process_id, high_priority, core_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, clock_now, request_time, process_id, high_priority, core_index,
        output ready
    );
endinterface

[src/dcpd_out_if.sv]
// valid/ready channel carrying one dispatcher result word
// no dependencies
`timescale 1ns / 1ps

interface dcpd_out_if;
    logic        valid;
    logic        ready;
    logic        started_running;
    logic        queue_full;
    logic        popped_valid;
    logic [7:0]  popped_process;
    logic [1:0]  next_device;
    logic [7:0]  next_process;
    logic [31:0] next_time;
    logic [31:0] core_busy_total;
    logic [31:0] disk_busy_total;

    modport source (
        output valid, started_running, queue_full, popped_valid, popped_process,
               next_device, next_process, next_time, core_busy_total, disk_busy_total,
        input  ready
    );
    modport sink (
        input  valid, started_running, queue_full, popped_valid, popped_process,
               next_device, next_process, next_time, core_busy_total, disk_busy_total,
        output ready
    );
endinterface

[src/dual_core_priority_dispatcher_core.sv]
// top level of the dual core priority dispatcher: input register, dispatch, result register
// depends on dcpd_pkg, dcpd_in_if, dcpd_out_if, dcpd_fifo, dcpd_sched and the defines header
//
// Usage
//   i_in carries one event word: cpu request, core completion, disk request or
//   disk completion, with its time, service duration, process and priority.
//   o_out carries one result word per event: what happened to the event, the
//   busy device that finishes first, and the saturating busy totals.
//   An accepted word passes through the input register and then the result
//   register before its result appears on o_out.
//   Throughput is one event per cycle: the event sits in an input register,
//   the dispatch logic reads the device slots and the three queue heads and
//   writes its result into the output register in one pass, so a new word is
//   taken whenever the output register is empty or being drained.
//   When o_out is stalled the result holds, one more word waits in the input
//   register, and then i_in.ready drops until the receiver takes the result.
//   Reset frees all devices, empties the queues and clears the busy totals;
//   no clearing pass is needed, the block takes words right after reset.
`timescale 1ns / 1ps
`include "dual_core_priority_dispatcher_core_defines.svh"

module dual_core_priority_dispatcher_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcpd_in_if.sink           i_in,
    dcpd_out_if.source        o_out
);

    dcpd_pkg::t_in_word  r_in;
    logic                r_in_valid;
    dcpd_pkg::t_out_word r_out;
    logic                r_out_valid;

    dcpd_pkg::t_out_word                        result;
    dcpd_pkg::t_fifo_ctl  [dcpd_pkg::NUM_Q-1:0] fifo_ctl;
    dcpd_pkg::t_fifo_stat [dcpd_pkg::NUM_Q-1:0] fifo_stat;
    logic                                       fire;
    logic                                       in_ready;

    assign fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in.cmd           <= dcpd_pkg::t_cmd'(i_in.cmd);
            r_in.clock_now     <= i_in.clock_now;
            r_in.request_time  <= i_in.request_time;
            r_in.process_id    <= i_in.process_id;
            r_in.high_priority <= i_in.high_priority;
            r_in.core_index    <= i_in.core_index;
        end
    end

    for (genvar q = 0; q < dcpd_pkg::NUM_Q; q++) begin : g_queue
        dcpd_fifo u_fifo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (fifo_ctl[q]),
            .o_stat  (fifo_stat[q])
        );
    end

    dcpd_sched u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_word      (r_in),
        .i_fifo_stat (fifo_stat),
        .o_fifo_ctl  (fifo_ctl),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.started_running = r_out.started_running;
    assign o_out.queue_full      = r_out.queue_full;
    assign o_out.popped_valid    = r_out.popped_valid;
    assign o_out.popped_process  = r_out.popped_process;
    assign o_out.next_device     = r_out.next_device;
    assign o_out.next_process    = r_out.next_process;
    assign o_out.next_time       = r_out.next_time;
    assign o_out.core_busy_total = r_out.core_busy_total;
    assign o_out.disk_busy_total = r_out.disk_busy_total;

    // a dispatched word always lands in the result register
    `DCPD_ASSERT_NEXT(a_fire_fills_out, fire, r_out_valid)

    // both stages full and receiver stalled means no new word is taken
    `DCPD_ASSERT_NOW(a_stall_blocks_in, r_in_valid && r_out_valid && !o_out.ready, !i_in.ready)

    // a word that started on a core was neither dropped nor pulled from a queue
    `DCPD_ASSERT_NOW(a_started_exclusive, o_out.valid && o_out.started_running,
        !o_out.queue_full && !o_out.popped_valid)

endmodule

[src/dcpd_fifo.sv]
// circular ready queue of {process, service time} entries
// depends on dcpd_pkg
`timescale 1ns / 1ps

module dcpd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcpd_pkg::t_fifo_ctl  i_ctl,
    output dcpd_pkg::t_fifo_stat o_stat
);

    dcpd_pkg::t_entry r_mem [dcpd_pkg::QUEUE_DEPTH];

    logic [dcpd_pkg::PTR_W-1:0] r_head;
    logic [dcpd_pkg::CNT_W-1:0] r_count;
    logic [dcpd_pkg::SUM_W-1:0] tail_sum;
    logic [dcpd_pkg::PTR_W-1:0] tail;

    always_comb begin
        tail_sum = dcpd_pkg::SUM_W'(r_head) + dcpd_pkg::SUM_W'(r_count);
        if (tail_sum >= dcpd_pkg::SUM_W'(dcpd_pkg::QUEUE_DEPTH)) begin
            tail_sum = tail_sum - dcpd_pkg::SUM_W'(dcpd_pkg::QUEUE_DEPTH);
        end
        tail = tail_sum[dcpd_pkg::PTR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[tail] <= i_ctl.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.pop) begin
                if (r_head == dcpd_pkg::PTR_W'(dcpd_pkg::QUEUE_DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + dcpd_pkg::PTR_W'(1);
                end
            end
            if (i_ctl.push && !i_ctl.pop) begin
                r_count <= r_count + dcpd_pkg::CNT_W'(1);
            end else if (i_ctl.pop && !i_ctl.push) begin
                r_count <= r_count - dcpd_pkg::CNT_W'(1);
            end
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == dcpd_pkg::CNT_W'(dcpd_pkg::QUEUE_DEPTH));
    assign o_stat.head  = r_mem[r_head];

endmodule

[src/dcpd_sched.sv]
// device slots, busy totals and the per-event dispatch decision
// depends on dcpd_pkg; drives the three dcpd_fifo queues
`timescale 1ns / 1ps

module dcpd_sched (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_fire,
    input  dcpd_pkg::t_in_word                          i_word,
    input  dcpd_pkg::t_fifo_stat [dcpd_pkg::NUM_Q-1:0]  i_fifo_stat,
    output dcpd_pkg::t_fifo_ctl  [dcpd_pkg::NUM_Q-1:0]  o_fifo_ctl,
    output dcpd_pkg::t_out_word                         o_result
);

    logic [dcpd_pkg::NUM_DEV-1:0] r_busy;
    logic [7:0]                   r_owner [dcpd_pkg::NUM_DEV];
    logic [31:0]                  r_done  [dcpd_pkg::NUM_DEV];
    logic [31:0]                  r_core_sum;
    logic [31:0]                  r_disk_sum;

    logic [dcpd_pkg::NUM_DEV-1:0] n_busy;
    logic [7:0]                   n_owner [dcpd_pkg::NUM_DEV];
    logic [31:0]                  n_done  [dcpd_pkg::NUM_DEV];
    logic [31:0]                  n_core_sum;
    logic [31:0]                  n_disk_sum;

    dcpd_pkg::t_fifo_ctl [dcpd_pkg::NUM_Q-1:0] ctl;

    logic           occ_en;
    dcpd_pkg::t_dev occ_dev;
    logic [7:0]     occ_proc;
    logic [15:0]    occ_time;
    logic [31:0]    occ_done;
    logic           rel_en;
    dcpd_pkg::t_dev rel_dev;
    logic           started;
    logic           full;
    logic           pv;
    dcpd_pkg::t_dev nd;
    logic [7:0]     np;
    logic [31:0]    nt;

    // dispatch decision
    always_comb begin
        occ_en   = 1'b0;
        occ_dev  = dcpd_pkg::DEV_CORE0;
        occ_proc = i_word.process_id;
        occ_time = i_word.request_time;
        rel_en   = 1'b0;
        rel_dev  = dcpd_pkg::DEV_CORE0;
        started  = 1'b0;
        full     = 1'b0;
        pv       = 1'b0;
        for (int q = 0; q < dcpd_pkg::NUM_Q; q++) begin
            ctl[q].push          = 1'b0;
            ctl[q].pop           = 1'b0;
            ctl[q].entry.proc    = i_word.process_id;
            ctl[q].entry.service = i_word.request_time;
        end

        case (i_word.cmd)
            dcpd_pkg::CMD_CPU_REQ: begin
                if (!r_busy[dcpd_pkg::DEV_CORE0]) begin
                    occ_en  = 1'b1;
                    occ_dev = dcpd_pkg::DEV_CORE0;
                    started = 1'b1;
                end else if (!r_busy[dcpd_pkg::DEV_CORE1]) begin
                    occ_en  = 1'b1;
                    occ_dev = dcpd_pkg::DEV_CORE1;
                    started = 1'b1;
                end else if (i_word.high_priority) begin
                    if (i_fifo_stat[dcpd_pkg::Q_HIGH].full) begin
                        full = 1'b1;
                    end else begin
                        ctl[dcpd_pkg::Q_HIGH].push = 1'b1;
                    end
                end else begin
                    if (i_fifo_stat[dcpd_pkg::Q_LOW].full) begin
                        full = 1'b1;
                    end else begin
                        ctl[dcpd_pkg::Q_LOW].push = 1'b1;
                    end
                end
            end
            dcpd_pkg::CMD_CORE_DONE: begin
                occ_dev = i_word.core_index ? dcpd_pkg::DEV_CORE1 : dcpd_pkg::DEV_CORE0;
                rel_dev = occ_dev;
                if (!i_fifo_stat[dcpd_pkg::Q_HIGH].empty) begin
                    ctl[dcpd_pkg::Q_HIGH].pop = 1'b1;
                    occ_en   = 1'b1;
                    occ_proc = i_fifo_stat[dcpd_pkg::Q_HIGH].head.proc;
                    occ_time = i_fifo_stat[dcpd_pkg::Q_HIGH].head.service;
                    pv       = 1'b1;
                end else if (!i_fifo_stat[dcpd_pkg::Q_LOW].empty) begin
                    ctl[dcpd_pkg::Q_LOW].pop = 1'b1;
                    occ_en   = 1'b1;
                    occ_proc = i_fifo_stat[dcpd_pkg::Q_LOW].head.proc;
                    occ_time = i_fifo_stat[dcpd_pkg::Q_LOW].head.service;
                    pv       = 1'b1;
                end else begin
                    rel_en = 1'b1;
                end
            end
            dcpd_pkg::CMD_DISK_REQ: begin
                if (!r_busy[dcpd_pkg::DEV_DISK]) begin
                    occ_en  = 1'b1;
                    occ_dev = dcpd_pkg::DEV_DISK;
                end else if (i_fifo_stat[dcpd_pkg::Q_DISK].full) begin
                    full = 1'b1;
                end else begin
                    ctl[dcpd_pkg::Q_DISK].push = 1'b1;
                end
            end
            dcpd_pkg::CMD_DISK_DONE: begin
                occ_dev = dcpd_pkg::DEV_DISK;
                rel_dev = dcpd_pkg::DEV_DISK;
                if (!i_fifo_stat[dcpd_pkg::Q_DISK].empty) begin
                    ctl[dcpd_pkg::Q_DISK].pop = 1'b1;
                    occ_en   = 1'b1;
                    occ_proc = i_fifo_stat[dcpd_pkg::Q_DISK].head.proc;
                    occ_time = i_fifo_stat[dcpd_pkg::Q_DISK].head.service;
                    pv       = 1'b1;
                end else begin
                    rel_en = 1'b1;
                end
            end
            default: begin
                rel_en = 1'b0;
            end
        endcase
    end

    // queue updates only land when the event is taken
    always_comb begin
        for (int q = 0; q < dcpd_pkg::NUM_Q; q++) begin
            o_fifo_ctl[q].push  = ctl[q].push & i_fire;
            o_fifo_ctl[q].pop   = ctl[q].pop & i_fire;
            o_fifo_ctl[q].entry = ctl[q].entry;
        end
    end

    assign occ_done = dcpd_pkg::sat_add(i_word.clock_now, 32'(occ_time));

    always_comb begin
        for (int d = 0; d < dcpd_pkg::NUM_DEV; d++) begin
            n_busy[d]  = r_busy[d];
            n_owner[d] = r_owner[d];
            n_done[d]  = r_done[d];
            if (occ_en && occ_dev == 2'(d)) begin
                n_busy[d]  = 1'b1;
                n_owner[d] = occ_proc;
                n_done[d]  = occ_done;
            end else if (rel_en && rel_dev == 2'(d)) begin
                n_busy[d]  = 1'b0;
                n_owner[d] = '0;
                n_done[d]  = '0;
            end
        end
        n_core_sum = r_core_sum;
        n_disk_sum = r_disk_sum;
        if (occ_en && occ_dev == dcpd_pkg::DEV_DISK) begin
            n_disk_sum = dcpd_pkg::sat_add(r_disk_sum, 32'(occ_time));
        end else if (occ_en) begin
            n_core_sum = dcpd_pkg::sat_add(r_core_sum, 32'(occ_time));
        end
    end

    // earliest nonzero done time over the updated slots, lowest index wins ties
    always_comb begin
        nd = dcpd_pkg::DEV_NONE;
        np = '0;
        nt = '0;
        for (int d = 0; d < dcpd_pkg::NUM_DEV; d++) begin
            if (n_busy[d] && n_done[d] != '0 && (nd == dcpd_pkg::DEV_NONE || n_done[d] < nt)) begin
                nd = 2'(d);
                np = n_owner[d];
                nt = n_done[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= '0;
            r_core_sum <= '0;
            r_disk_sum <= '0;
            for (int d = 0; d < dcpd_pkg::NUM_DEV; d++) begin
                r_owner[d] <= '0;
                r_done[d]  <= '0;
            end
        end else if (i_fire) begin
            r_busy     <= n_busy;
            r_core_sum <= n_core_sum;
            r_disk_sum <= n_disk_sum;
            for (int d = 0; d < dcpd_pkg::NUM_DEV; d++) begin
                r_owner[d] <= n_owner[d];
                r_done[d]  <= n_done[d];
            end
        end
    end

    assign o_result.started_running = started;
    assign o_result.queue_full      = full;
    assign o_result.popped_valid    = pv;
    assign o_result.popped_process  = pv ? occ_proc : 8'd0;
    assign o_result.next_device     = nd;
    assign o_result.next_process    = np;
    assign o_result.next_time       = nt;
    assign o_result.core_busy_total = n_core_sum;
    assign o_result.disk_busy_total = n_disk_sum;

endmodule

[bench/dual_core_priority_dispatcher_core_tb.sv]
// testbench for dual_core_priority_dispatcher_core: a directed table, then random event words
// under several idle/stall mixes, checked against a predictor or, for rows with typed-in results, against those
// depends on dcpd_pkg, dcpd_in_if, dcpd_out_if and the block itself
`timescale 1ns / 1ps

module dual_core_priority_dispatcher_core_tb;
    import dcpd_pkg::*;

    typedef struct {
        t_in_word  ev;
        bit        known;
        t_out_word result;
    } t_dir_row;

    localparam int DIR_ROWS    = 20;
    localparam int RAND_BLOCKS = 12;
    localparam int BLOCK_WORDS = 128;

    logic i_clk;
    logic i_rst_n;

    dcpd_in_if  in_ch ();
    dcpd_out_if out_ch ();

    dual_core_priority_dispatcher_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted device slots and ready queues
    logic       slot_busy   [NUM_DEV];
    logic [7:0] slot_owner  [NUM_DEV];
    logic [31:0] slot_finish [NUM_DEV];
    t_entry     ready_q     [NUM_Q][$];
    logic [31:0] core_time_sum;
    logic [31:0] disk_time_sum;

    t_out_word pending_results [$];
    int        mismatch_count;
    int        idle_pct;
    int        stall_pct;
    bit        row_known;
    t_out_word row_result;

    // directed words; results typed in only where they are plain to see
    t_dir_row plan [DIR_ROWS] = '{
        // completions of free devices with empty queues
        '{'{CMD_CORE_DONE, 32'd5, 16'hFFFF, 8'h55, 1'b1, 1'b0}, 1'b1,
          '{1'b0, 1'b0, 1'b0, 8'h00, DEV_NONE, 8'h00, 32'h0, 32'h0, 32'h0}},
        '{'{CMD_DISK_DONE, 32'd0, 16'h0000, 8'h00, 1'b0, 1'b1}, 1'b1,
          '{1'b0, 1'b0, 1'b0, 8'h00, DEV_NONE, 8'h00, 32'h0, 32'h0, 32'h0}},
        // core 0 with a zero done time is never reported
        '{'{CMD_CPU_REQ, 32'd0, 16'h0000, 8'hFF, 1'b0, 1'b0}, 1'b1,
          '{1'b1, 1'b0, 1'b0, 8'h00, DEV_NONE, 8'h00, 32'h0, 32'h0, 32'h0}},
        // done time saturates
        '{'{CMD_CPU_REQ, 32'hFFFF_FFFF, 16'hFFFF, 8'h01, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 1'b0, 1'b0, 8'h00, DEV_CORE1, 8'h01, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0}},
        '{'{CMD_CPU_REQ, 32'd10, 16'h1234, 8'h10, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_CPU_REQ, 32'd11, 16'h0001, 8'h20, 1'b0, 1'b1}, 1'b0, '0},
        '{'{CMD_CPU_REQ, 32'd12, 16'h0007, 8'h11, 1'b1, 1'b0}, 1'b0, '0},
        // high queue drains before low
        '{'{CMD_CORE_DONE, 32'd100, 16'h0000, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{'{CMD_CORE_DONE, 32'd100, 16'hFFFF, 8'hFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_CORE_DONE, 32'd50, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{CMD_CORE_DONE, 32'd0, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
        // disk starts at once but started_running stays low
        '{'{CMD_DISK_REQ, 32'hFFFF_FFFF, 16'h0000, 8'hAA, 1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_DISK_REQ, 32'd3, 16'hFFFF, 8'hAB, 1'b0, 1'b0}, 1'b0, '0},
        '{'{CMD_DISK_DONE, 32'd10, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{CMD_DISK_DONE, 32'd20, 16'h0000, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
        // ties between devices go to the lowest index
        '{'{CMD_CPU_REQ, 32'd1000, 16'h0000, 8'h30, 1'b0, 1'b0}, 1'b0, '0},
        '{'{CMD_DISK_REQ, 32'd500, 16'd500, 8'h31, 1'b0, 1'b0}, 1'b0, '0},
        '{'{CMD_CPU_REQ, 32'd900, 16'h0000, 8'h33, 1'b0, 1'b1}, 1'b0, '0},
        '{'{CMD_CORE_DONE, 32'd1000, 16'h0000, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_CORE_DONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1}, 1'b0, '0}
    };

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void seat(input int dev, input logic [7:0] proc,
                                 input logic [31:0] now, input logic [15:0] dur);
        slot_busy[dev]   = 1'b1;
        slot_owner[dev]  = proc;
        slot_finish[dev] = add_clamped(now, {16'h0, dur});
        if (dev == int'(DEV_DISK))
            disk_time_sum = add_clamped(disk_time_sum, {16'h0, dur});
        else
            core_time_sum = add_clamped(core_time_sum, {16'h0, dur});
    endfunction

    function automatic void free_slot(input int dev);
        slot_busy[dev]   = 1'b0;
        slot_owner[dev]  = 8'h0;
        slot_finish[dev] = 32'h0;
    endfunction

    function automatic t_out_word predict_dispatch(input t_in_word w);
        t_out_word r;
        t_entry    e;
        int        q;
        r = '0;
        r.next_device = DEV_NONE;
        case (w.cmd)
            CMD_CPU_REQ: begin
                if (!slot_busy[DEV_CORE0]) begin
                    seat(int'(DEV_CORE0), w.process_id, w.clock_now, w.request_time);
                    r.started_running = 1'b1;
                end else if (!slot_busy[DEV_CORE1]) begin
                    seat(int'(DEV_CORE1), w.process_id, w.clock_now, w.request_time);
                    r.started_running = 1'b1;
                end else begin
                    q = w.high_priority ? Q_HIGH : Q_LOW;
                    if (ready_q[q].size() >= QUEUE_DEPTH)
                        r.queue_full = 1'b1;
                    else
                        ready_q[q].insert(ready_q[q].size(),
                                          t_entry'{w.process_id, w.request_time});
                end
            end
            CMD_CORE_DONE: begin
                if (ready_q[Q_HIGH].size() != 0 || ready_q[Q_LOW].size() != 0) begin
                    q = (ready_q[Q_HIGH].size() != 0) ? Q_HIGH : Q_LOW;
                    e = ready_q[q][0];
                    ready_q[q].delete(0);
                    seat(int'(w.core_index), e.proc, w.clock_now, e.service);
                    r.popped_valid   = 1'b1;
                    r.popped_process = e.proc;
                end else begin
                    free_slot(int'(w.core_index));
                end
            end
            CMD_DISK_REQ: begin
                if (!slot_busy[DEV_DISK])
                    seat(int'(DEV_DISK), w.process_id, w.clock_now, w.request_time);
                else if (ready_q[Q_DISK].size() >= QUEUE_DEPTH)
                    r.queue_full = 1'b1;
                else
                    ready_q[Q_DISK].insert(ready_q[Q_DISK].size(),
                                           t_entry'{w.process_id, w.request_time});
            end
            default: begin
                if (ready_q[Q_DISK].size() != 0) begin
                    e = ready_q[Q_DISK][0];
                    ready_q[Q_DISK].delete(0);
                    seat(int'(DEV_DISK), e.proc, w.clock_now, e.service);
                    r.popped_valid   = 1'b1;
                    r.popped_process = e.proc;
                end else begin
                    free_slot(int'(DEV_DISK));
                end
            end
        endcase
        for (int d = 0; d < NUM_DEV; d++) begin
            if (slot_busy[d] && slot_finish[d] != 32'h0 &&
                (r.next_device == DEV_NONE || slot_finish[d] < r.next_time)) begin
                r.next_device  = t_dev'(d);
                r.next_process = slot_owner[d];
                r.next_time    = slot_finish[d];
            end
        end
        r.core_busy_total = core_time_sum;
        r.disk_busy_total = disk_time_sum;
        return r;
    endfunction

    function automatic t_in_word random_event(input int req_pct);
        t_in_word w;
        if ($urandom_range(99) < req_pct)
            w.cmd = $urandom_range(1) ? CMD_CPU_REQ : CMD_DISK_REQ;
        else
            w.cmd = $urandom_range(1) ? CMD_CORE_DONE : CMD_DISK_DONE;
        case ($urandom_range(7))
            0:       w.clock_now = $urandom_range(15);
            1:       w.clock_now = 32'hFFFF_FFFF - $urandom_range(65535);
            default: w.clock_now = $urandom;
        endcase
        case ($urandom_range(7))
            0:       w.request_time = 16'h0000;
            1:       w.request_time = 16'hFFFF;
            default: w.request_time = 16'($urandom);
        endcase
        w.process_id    = 8'($urandom);
        w.high_priority = 1'($urandom_range(1));
        w.core_index    = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_event(input t_in_word w, input bit known, input t_out_word result);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        row_known  = known;
        row_result = result;
        in_ch.cmd           <= w.cmd;
        in_ch.clock_now     <= w.clock_now;
        in_ch.request_time  <= w.request_time;
        in_ch.process_id    <= w.process_id;
        in_ch.high_priority <= w.high_priority;
        in_ch.core_index    <= w.core_index;
        in_ch.valid         <= 1'b1;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender holds off until every predicted result has come back or the limit runs out
    task automatic settle(input int limit);
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (pending_results.size() != 0 && waited < limit);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin : watch
        t_in_word  ev;
        t_out_word want;
        if (i_rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
            ev.cmd           = t_cmd'(in_ch.cmd);
            ev.clock_now     = in_ch.clock_now;
            ev.request_time  = in_ch.request_time;
            ev.process_id    = in_ch.process_id;
            ev.high_priority = in_ch.high_priority;
            ev.core_index    = in_ch.core_index;
            want = predict_dispatch(ev);
            pending_results.insert(pending_results.size(), row_known ? row_result : want);
        end
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with nothing expected, expected none, actual %0h",
                         $time, out_ch.next_time);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("started_running", 32'(want.started_running),
                            32'(out_ch.started_running));
                check_field("queue_full", 32'(want.queue_full), 32'(out_ch.queue_full));
                check_field("popped_valid", 32'(want.popped_valid), 32'(out_ch.popped_valid));
                check_field("popped_process", 32'(want.popped_process),
                            32'(out_ch.popped_process));
                check_field("next_device", 32'(want.next_device), 32'(out_ch.next_device));
                check_field("next_process", 32'(want.next_process), 32'(out_ch.next_process));
                check_field("next_time", want.next_time, out_ch.next_time);
                check_field("core_busy_total", want.core_busy_total, out_ch.core_busy_total);
                check_field("disk_busy_total", want.disk_busy_total, out_ch.disk_busy_total);
            end
        end
    end

    initial begin
        int phase_idle  [4] = '{0, 60, 0, 10};
        int phase_stall [4] = '{0, 0, 60, 10};
        int req_mix     [3] = '{75, 35, 55};
        for (int d = 0; d < NUM_DEV; d++)
            free_slot(d);
        core_time_sum  = 32'h0;
        disk_time_sum  = 32'h0;
        mismatch_count = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        row_known      = 1'b0;
        row_result     = '0;
        i_rst_n        = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.cmd           = CMD_CPU_REQ;
        in_ch.clock_now     = 32'h0;
        in_ch.request_time  = 16'h0;
        in_ch.process_id    = 8'h0;
        in_ch.high_priority = 1'b0;
        in_ch.core_index    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_event(plan[i].ev, plan[i].known, plan[i].result);
        settle(100000);

        // random words; request-heavy blocks fill the queues, completion-heavy ones drain them
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            idle_pct  = phase_idle[b % 4];
            stall_pct = phase_stall[b % 4];
            repeat (BLOCK_WORDS)
                send_event(random_event(req_mix[b % 3]), 1'b0, '0);
            settle(100000);
        end

        idle_pct  = 0;
        stall_pct = 0;
        settle(20000);
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            mismatch_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_results.size());
        end
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/dcpd_pkg.sv
src/dcpd_in_if.sv
src/dcpd_out_if.sv
src/dcpd_fifo.sv
src/dcpd_sched.sv
src/dual_core_priority_dispatcher_core.sv
bench/dual_core_priority_dispatcher_core_tb.sv
